// File: rtl/pwmc_pkg.sv
`timescale 1ns / 1ps
package pwmc_pkg;

	localparam int QW = 30;
	localparam int CLK_W = 31;
	localparam int NUM_CHANNELS_DEF = 5;
	localparam int SPAN_SHIFT = 17;
	localparam logic [QW-1:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [CLK_W-1:0] CLK_RST = 31'd66000000;
	localparam logic [5:0] CH_STRIDE = 6'd12;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_DUTY   = 2'd2,
		ST_PERIOD = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]    ch;
		logic [QW-1:0] duty;
		logic [QW-1:0] per;
		status_t       st;
		logic [QW-1:0] rate;
		logic [1:0]    idx;
	} sel_t;

	typedef struct packed {
		logic [2:0]    ch;
		status_t       st;
		logic [QW-1:0] rate;
		logic [1:0]    idx;
	} fin_t;

endpackage

// File: rtl/pwm_period_duty_to_counts.sv
// Pipeline from input beat to result beat: select stages, tick-rate divider, count divider, output register.
// Throughput: one beat per cycle; the pipeline advances as one, stalled only by m_tready.
// Reset (arst_n low): all valid bits clear, source clock register returns to 66 MHz.
`timescale 1ns / 1ps
module pwm_period_duty_to_counts #(
	parameter int NUM_CHANNELS = pwmc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pwmc_pkg::CLK_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// channel[2:0], duty_time_ns[33:3], period_time_ns[64:34], zero pad
	input  logic [71:0]                s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status[1:0], reload_count[33:2], compare_count[65:34], tick_rate_hz[95:66],
	// divider_index[97:96], register_offset[103:98]
	output logic [103:0]               m_tdata
);
	import pwmc_pkg::*;

	logic [CLK_W-1:0] clk_hz_q;
	logic             adv;
	logic             m_tvalid_q;
	logic [103:0]     m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RST;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	logic sel_v;
	sel_t sel;

	pwmc_sel u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.clk_hz    (clk_hz_q),
		.in_valid  (s_tvalid),
		.ch        (s_tdata[2:0]),
		.duty      (s_tdata[33:3]),
		.per       (s_tdata[64:34]),
		.out_valid (sel_v),
		.out       (sel)
	);

	logic [QW-1:0] den1;
	logic          d1_v;
	logic [QW-1:0] tick;
	sel_t          d1_side;

	assign den1 = (sel.st == ST_OK) ? sel.rate : QW'(1);

	pwmc_div #(.W(QW), .LANES(1), .SW($bits(sel_t))) u_tick_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sel_v),
		.num       (NS_PER_SEC),
		.den       (den1),
		.side      (sel),
		.out_valid (d1_v),
		.quo       (tick),
		.side_out  (d1_side)
	);

	fin_t            f_in;
	fin_t            f;
	logic            d2_v;
	logic [2*QW-1:0] q2;

	always_comb begin
		f_in.ch   = d1_side.ch;
		f_in.st   = d1_side.st;
		f_in.rate = d1_side.rate;
		f_in.idx  = d1_side.idx;
	end

	pwmc_div #(.W(QW), .LANES(2), .SW($bits(fin_t))) u_count_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d1_v),
		.num       ({d1_side.duty, d1_side.per}),
		.den       (tick),
		.side      (f_in),
		.out_valid (d2_v),
		.quo       (q2),
		.side_out  (f)
	);

	logic [QW-1:0] reload;
	logic [QW-1:0] dq;
	logic [QW-1:0] cmp;
	logic [5:0]    offset;
	logic [103:0]  res;

	assign reload = q2[QW-1:0];
	assign dq     = q2[2*QW-1:QW];

	always_comb begin
		if (dq == '0) begin
			cmp = (reload == '0) ? '0 : reload - QW'(1);
		end else begin
			cmp = reload - dq;
		end
		if ({1'b0, f.ch} < 4'(NUM_CHANNELS)) begin
			offset = 6'(f.ch) * CH_STRIDE;
		end else begin
			offset = '0;
		end
		res = '0;
		res[1:0] = f.st;
		if (f.st == ST_OK) begin
			res[33:2]   = 32'(reload);
			res[65:34]  = 32'(cmp);
			res[95:66]  = f.rate;
			res[97:96]  = f.idx;
			res[103:98] = offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule

// File: rtl/pwmc_div.sv
`timescale 1ns / 1ps
module pwmc_div #(
	parameter int W = 30,
	parameter int LANES = 1,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [LANES*W-1:0] num,
	input  logic [W-1:0]       den,
	input  logic [SW-1:0]      side,
	output logic               out_valid,
	output logic [LANES*W-1:0] quo,
	output logic [SW-1:0]      side_out
);
	logic               v_s    [1:W];
	logic [SW-1:0]      side_s [1:W];
	logic [LANES*W-1:0] quo_s  [1:W];
	logic [W-1:0]       den_s  [1:W-1];
	logic [LANES*W-1:0] num_s  [1:W-1];
	logic [LANES*W-1:0] rem_s  [1:W-1];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic               v_i;
		logic [W-1:0]       den_i;
		logic [SW-1:0]      side_i;
		logic [LANES*W-1:0] num_i;
		logic [LANES*W-1:0] rem_i;
		logic [LANES*W-1:0] quo_i;
		logic [LANES*W-1:0] rem_n;
		logic [LANES*W-1:0] quo_n;

		if (i == 0) begin : g_head
			assign v_i    = in_valid;
			assign den_i  = den;
			assign side_i = side;
			assign num_i  = num;
			assign rem_i  = '0;
			assign quo_i  = '0;
		end else begin : g_body
			assign v_i    = v_s[i];
			assign den_i  = den_s[i];
			assign side_i = side_s[i];
			assign num_i  = num_s[i];
			assign rem_i  = rem_s[i];
			assign quo_i  = quo_s[i];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [W:0] t;
			logic       ge;
			logic [W:0] diff;
			assign t    = {rem_i[l*W +: W], num_i[l*W + W-1-i]};
			assign diff = t - {1'b0, den_i};
			assign ge   = (t >= {1'b0, den_i});
			assign rem_n[l*W +: W] = ge ? diff[W-1:0] : t[W-1:0];
			assign quo_n[l*W +: W] = {quo_i[l*W +: W-1], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_i;
				quo_s[i+1]  <= quo_n;
			end
		end

		if (i < W-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[i+1] <= den_i;
					num_s[i+1] <= num_i;
					rem_s[i+1] <= rem_n;
				end
			end
		end
	end

	assign out_valid = v_s[W];
	assign quo       = quo_s[W];
	assign side_out  = side_s[W];
endmodule

// File: rtl/pwmc_sel.sv
`timescale 1ns / 1ps
module pwmc_sel (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [pwmc_pkg::CLK_W-1:0] clk_hz,
	input  logic                      in_valid,
	input  logic [2:0]                ch,
	input  logic [30:0]               duty,
	input  logic [30:0]               per,
	output logic                      out_valid,
	output pwmc_pkg::sel_t            out
);
	import pwmc_pkg::*;

	localparam logic [45:0] LIMIT = 46'(NS_PER_SEC);

	logic          v_s    [1:4];
	logic [2:0]    ch_s   [1:4];
	logic [30:0]   duty_s [1:4];
	logic [30:0]   per_s  [1:4];
	status_t       st_s   [1:4];
	logic [3:0]    fit_s  [1:4];
	status_t       st0;

	always_comb begin
		if (per > 31'(NS_PER_SEC) || duty > 31'(NS_PER_SEC)) begin
			st0 = ST_RANGE;
		end else if (duty > per) begin
			st0 = ST_DUTY;
		end else if (per == '0) begin
			st0 = ST_PERIOD;
		end else begin
			st0 = ST_OK;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_fit
		logic             v_i;
		logic [2:0]       ch_i;
		logic [30:0]      duty_i;
		logic [30:0]      per_i;
		status_t          st_i;
		logic [3:0]       fit_i;
		logic [CLK_W-1:0] sh;
		logic [14:0]      span;
		logic [45:0]      prod;
		logic [3:0]       fit_n;

		if (k == 0) begin : g_head
			assign v_i    = in_valid;
			assign ch_i   = ch;
			assign duty_i = duty;
			assign per_i  = per;
			assign st_i   = st0;
			assign fit_i  = '0;
		end else begin : g_body
			assign v_i    = v_s[k];
			assign ch_i   = ch_s[k];
			assign duty_i = duty_s[k];
			assign per_i  = per_s[k];
			assign st_i   = st_s[k];
			assign fit_i  = fit_s[k];
		end

		assign sh   = clk_hz >> (SPAN_SHIFT + k);
		assign span = 15'(sh) + 15'd1;
		assign prod = 46'(span) * 46'(per_i);
		always_comb begin
			fit_n    = fit_i;
			fit_n[k] = (prod <= LIMIT);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ch_s[k+1]   <= ch_i;
				duty_s[k+1] <= duty_i;
				per_s[k+1]  <= per_i;
				st_s[k+1]   <= st_i;
				fit_s[k+1]  <= fit_n;
			end
		end
	end

	logic [1:0]       idx;
	logic [CLK_W-1:0] rate_w;
	logic [QW-1:0]    rate;
	sel_t             nxt;

	always_comb begin
		priority if (fit_s[4][0]) idx = 2'd0;
		else if (fit_s[4][1])     idx = 2'd1;
		else if (fit_s[4][2])     idx = 2'd2;
		else                      idx = 2'd3;
	end

	assign rate_w = clk_hz >> ({1'b0, idx} + 3'd1);
	assign rate   = rate_w[QW-1:0];

	always_comb begin
		nxt.ch   = ch_s[4];
		nxt.duty = duty_s[4][QW-1:0];
		nxt.per  = per_s[4][QW-1:0];
		nxt.st   = st_s[4];
		nxt.rate = rate;
		nxt.idx  = idx;
		if (st_s[4] == ST_OK && (rate == '0 || rate > NS_PER_SEC)) begin
			nxt.st = ST_PERIOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[4];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out <= nxt;
		end
	end
endmodule

// File: verif/pwm_period_duty_to_counts_tb.sv
`timescale 1ns / 1ps
module pwm_period_duty_to_counts_tb;
	import pwmc_pkg::*;

	typedef struct packed {
		logic [5:0]  offset;
		logic [1:0]  div_idx;
		logic [29:0] rate;
		logic [31:0] compare;
		logic [31:0] reload;
		status_t     st;
	} counts_t;

	localparam longint NS_SEC = 64'd1000000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CLK_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;

	logic [30:0] clock_hz;
	counts_t expected_counts[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;

	pwm_period_duty_to_counts dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#100ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic counts_t predict_counts(logic [2:0] ch, logic [30:0] duty,
			logic [30:0] per);
		counts_t r;
		longint unsigned freq, rate, tick, cmp_ticks, k;
		longint cmp;
		bit found;
		r = '0;
		r.st = ST_OK;
		if (per > NS_SEC || duty > NS_SEC) begin
			r.st = ST_RANGE;
		end else if (duty > per) begin
			r.st = ST_DUTY;
		end else if (per == 0) begin
			r.st = ST_PERIOD;
		end else begin
			freq = NS_SEC / per;
			found = 1'b0;
			rate = clock_hz / 16;
			r.div_idx = 2'd3;
			for (k = 0; k < 4; k++) begin
				if (!found && (clock_hz / ((64'd2 << k) << 16)) < freq) begin
					found = 1'b1;
					r.div_idx = k[1:0];
					rate = clock_hz / (64'd2 << k);
				end
			end
			if (rate == 0 || rate > NS_SEC) begin
				r.st = ST_PERIOD;
				r.div_idx = '0;
			end else begin
				tick = NS_SEC / rate;
				r.rate = rate[29:0];
				r.reload = per / tick;
				cmp_ticks = duty / tick;
				cmp = longint'(per / tick) - longint'(cmp_ticks);
				if (cmp_ticks == 0) cmp--;
				if (cmp < 0) cmp = 0;
				r.compare = cmp[31:0];
				if (ch < 5) r.offset = ch * 6'd12;
			end
		end
		return r;
	endfunction

	task automatic send_request(logic [2:0] ch, logic [30:0] duty, logic [30:0] per);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, per, duty, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_counts.push_back(predict_counts(ch, duty, per));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_counts.size() == 0) begin
					$display("%t: unexpected result beat %h", $time, m_tdata);
					errors++;
				end else begin
					counts_t e, a;
					e = expected_counts.pop_front();
					a = m_tdata;
					if (a !== e) begin
						$display("%t: exp st=%0d rl=%0d cmp=%0d rate=%0d idx=%0d off=%0d",
							$time, e.st, e.reload, e.compare, e.rate, e.div_idx, e.offset);
						$display("%t: act st=%0d rl=%0d cmp=%0d rate=%0d idx=%0d off=%0d",
							$time, a.st, a.reload, a.compare, a.rate, a.div_idx, a.offset);
						errors++;
					end
				end
			end
			m_tready <= !hold_off && !(recv_idle_pct > 0 &&
				$urandom_range(99, 0) < recv_idle_pct);
		end
	end

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_clock(logic [30:0] hz);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we <= 1'b0;
		clock_hz = hz;
		@(posedge clk);
	endtask

	function automatic logic [30:0] rand_time();
		case ($urandom_range(5, 0))
			0: return 31'($urandom_range(1000, 0));
			1: return 31'($urandom_range(100000, 0));
			2: return 31'($urandom_range(1000000000, 0));
			3: return 31'($urandom());
			4: return 31'($urandom_range(20000000, 0));
			default: return 31'($urandom_range(1000000000, 999990000));
		endcase
	endfunction

	task automatic random_requests(int n);
		logic [30:0] d, p;
		for (int i = 0; i < n; i++) begin
			p = rand_time();
			d = ($urandom_range(3, 0) == 0) ? rand_time() :
				((p == 0) ? 31'd0 : 31'($urandom_range(p, 0)));
			send_request(3'($urandom()), d, p);
		end
	endtask

	task automatic test_directed;
		send_request(3'd0, 31'd0, 31'd0);
		send_request(3'd7, 31'h7fffffff, 31'h7fffffff);
		send_request(3'd1, 31'd0, 31'h7fffffff);
		send_request(3'd2, 31'h7fffffff, 31'd1000);
		send_request(3'd3, 31'd1000000000, 31'd1000000000);
		send_request(3'd4, 31'd1000000001, 31'd1000000000);
		send_request(3'd5, 31'd0, 31'd1000000001);
		send_request(3'd4, 31'd500, 31'd100);
		send_request(3'd1, 31'd0, 31'd1);
		send_request(3'd2, 31'd1, 31'd1);
		send_request(3'd3, 31'd0, 31'd50000);
		send_request(3'd4, 31'd50000, 31'd50000);
		send_request(3'd6, 31'd1000, 31'd50000);
		send_request(3'd0, 31'd25000, 31'd50000);
		send_request(3'd1, 31'd10, 31'd20000000);
		send_request(3'd2, 31'd1, 31'd100000000);
		send_request(3'd3, 31'd1, 31'd1000000);
	endtask

	task automatic test_clock_settings;
		logic [30:0] clocks[6];
		clocks = '{31'd1, 31'd0, 31'h7fffffff, 31'd2000000000, 31'd1000000, 31'd125000000};
		foreach (clocks[i]) begin
			write_clock(clocks[i]);
			test_directed();
			random_requests(120);
		end
		write_clock(31'($urandom_range(2000000000, 1)));
		random_requests(100);
		write_clock(31'd66000000);
	endtask

	task automatic test_backpressure;
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_requests(150);
		join
	endtask

	initial begin
		clock_hz = CLK_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 7;
		recv_idle_pct = 54;
		test_directed();
		random_requests(400);
		send_idle_pct = 54;
		recv_idle_pct = 7;
		random_requests(300);
		test_clock_settings();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_requests(200);
		test_backpressure();
		drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
